// ===== rtl/feal4_pkg.sv =====
// Shared types, constants and round function for the FEAL-4 cipher pipeline.
package feal4_pkg;

   localparam int unsigned KEY_W      = 64;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned SUBKEY_W   = 16;
   localparam int unsigned NUM_ROUNDS = 4;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // word traveling down the cell chain
   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] l;
      logic [WORD_W-1:0] r;
   } stage_type;

   function automatic logic [7:0] sbox(input logic [7:0] a, input logic [7:0] b,
                                       input logic one);
      logic [7:0] s;
      s = a + b + {7'd0, one};
      return {s[5:0], s[7:6]};
   endfunction

   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] x,
                                                  input logic [SUBKEY_W-1:0] sub);
      logic [7:0] f0, f1, f2, f3;
      f1 = x[15:8] ^ sub[7:0] ^ x[7:0];
      f2 = x[23:16] ^ sub[15:8] ^ x[31:24];
      f1 = sbox(f1, f2, 1'b1);
      f2 = sbox(f2, f1, 1'b0);
      f0 = sbox(x[7:0], f1, 1'b0);
      f3 = sbox(x[31:24], f2, 1'b1);
      return {f3, f2, f1, f0};
   endfunction

endpackage

// ===== rtl/feal4_round_cell.sv =====
// One round cell: applies a single Feistel round and holds the word for the next cell.
module feal4_round_cell
   import feal4_pkg::*;
#(
   parameter int unsigned STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [KEY_W-1:0] key,
   input  logic             in_valid,
   output logic             in_ready,
   input  stage_type        in_word,
   output logic             out_valid,
   input  logic             out_ready,
   output stage_type        out_word
);

   localparam logic [1:0] ENC_Q = 2'(NUM_ROUNDS - 1 - STAGE);
   localparam logic [1:0] DEC_Q = 2'(STAGE);
   localparam bit         LAST  = (STAGE == NUM_ROUNDS - 1);

   logic                valid_ff, valid_in;
   stage_type           word_ff, word_in;
   logic [1:0]          q;
   logic [SUBKEY_W-1:0] sub;
   logic [WORD_W-1:0]   f;

   assign q   = (in_word.cmd == CMD_DECRYPT) ? DEC_Q : ENC_Q;
   assign sub = key[{q, 4'd0} +: SUBKEY_W];
   assign f   = round_fn(in_word.r, sub);

   // a cell takes a new word when empty or when its word moves on
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in     = in_word;
      if (LAST) begin
         // final round: no swap, then fold L back into R
         word_in.l = in_word.l ^ f;
         word_in.r = in_word.r ^ in_word.l ^ f;
      end else begin
         word_in.l = in_word.r;
         word_in.r = in_word.l ^ f;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/feal4_block_cipher_unit.sv =====
// Each accepted req word passes through one registered cell per round on its way to rsp_valid.
// Throughput: one block per cycle; each round cell stalls only when its successor is full.
// The four round cells form the pipeline; whitening sits at its entry and exit.
// Reset (synchronous, active high) empties every cell and clears the key to zero.
// The key may be rewritten only while no block is in flight.
module feal4_block_cipher_unit
   import feal4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [63:0]      req_block_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [63:0]      rsp_block_out,
   input  logic             csr_write_enable,
   input  logic [KEY_W-1:0] csr_write_data
);

   logic [KEY_W-1:0]  key_ff;
   logic [WORD_W-1:0] kw0, kw1;
   stage_type         link_word  [NUM_ROUNDS+1];
   logic              link_valid [NUM_ROUNDS+1];
   logic              link_ready [NUM_ROUNDS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         key_ff <= csr_write_data;
      end
   end

   assign kw0 = key_ff[WORD_W-1:0];
   assign kw1 = key_ff[KEY_W-1:WORD_W];

   // entry whitening, then R ^= L
   always_comb begin
      link_word[0].cmd = req_command;
      link_word[0].l   = req_block_in[63:32] ^ kw1;
      link_word[0].r   = req_block_in[31:0] ^ kw0 ^ req_block_in[63:32] ^ kw1;
   end
   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
      feal4_round_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key_ff),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_word   (link_word[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_word  (link_word[i+1])
      );
   end

   assign link_ready[NUM_ROUNDS] = rsp_ready;
   assign rsp_valid     = link_valid[NUM_ROUNDS];
   assign rsp_block_out = {link_word[NUM_ROUNDS].l ^ kw1, link_word[NUM_ROUNDS].r ^ kw0};

endmodule

// ===== tb/feal4_block_cipher_checker.sv =====
// Checker for the FEAL-4 unit: tracks the key, predicts each block and compares results.
module feal4_block_cipher_checker
   import feal4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_command,
   input  logic [63:0]      req_block_in,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [63:0]      rsp_block_out,
   input  logic             csr_write_enable,
   input  logic [KEY_W-1:0] csr_write_data,
   output int unsigned      fail_count,
   output int unsigned      pending_count
);

   logic [KEY_W-1:0] key_shadow;
   logic [63:0]      expected_blocks[$];

   // byte add with optional carry-in, then rotate left by two
   function automatic logic [7:0] mix_byte(input logic [7:0] a, input logic [7:0] b,
                                           input logic carry_in);
      logic [7:0] sum;
      sum = a + b + 8'(carry_in);
      return 8'((sum << 2) | (sum >> 6));
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [15:0] sub);
      logic [7:0] b0, b1, b2, b3;
      logic [7:0] m0, m1, m2, m3;
      b0 = x[7:0];
      b1 = x[15:8];
      b2 = x[23:16];
      b3 = x[31:24];
      m1 = mix_byte(b1 ^ sub[7:0] ^ b0, b2 ^ sub[15:8] ^ b3, 1'b1);
      m2 = mix_byte(b2 ^ sub[15:8] ^ b3, m1, 1'b0);
      m0 = mix_byte(b0, m1, 1'b0);
      m3 = mix_byte(b3, m2, 1'b1);
      return {m3, m2, m1, m0};
   endfunction

   function automatic logic [63:0] feal4_transform(input logic cmd, input logic [63:0] blk,
                                                   input logic [KEY_W-1:0] key);
      logic [31:0] lw, rw, tmp;
      logic [1:0]  q;
      int          i;
      rw = blk[31:0] ^ key[31:0];
      lw = blk[63:32] ^ key[63:32];
      rw = rw ^ lw;
      // encrypt walks the subkeys from the top quarter down, decrypt from the bottom up
      for (i = 0; i < 3; i++) begin
         q   = (cmd == CMD_DECRYPT) ? 2'(i) : 2'(3 - i);
         tmp = rw;
         rw  = lw ^ round_mix(rw, key[16*q +: 16]);
         lw  = tmp;
      end
      q  = (cmd == CMD_DECRYPT) ? 2'd3 : 2'd0;
      lw = lw ^ round_mix(rw, key[16*q +: 16]);
      rw = rw ^ lw;
      lw = lw ^ key[63:32];
      rw = rw ^ key[31:0];
      return {lw, rw};
   endfunction

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         key_shadow <= '0;
         fail_count = 0;
         expected_blocks.delete();
      end else begin
         if (csr_write_enable)
            key_shadow <= csr_write_data;
         if (req_valid && req_ready)
            expected_blocks.push_back(feal4_transform(req_command, req_block_in, key_shadow));
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("block_out: no word expected, actual %h", rsp_block_out);
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_block_out !== want) begin
                  $error("block_out: expected %h actual %h", want, rsp_block_out);
                  fail_count++;
               end
            end
         end
      end
      pending_count <= expected_blocks.size();
   end

endmodule

// ===== tb/tb_feal4_block_cipher_unit.sv =====
// Top of the FEAL-4 unit testbench: clock, reset, stimulus, key loads and verdict.
module tb_feal4_block_cipher_unit;
   import feal4_pkg::*;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_command      = CMD_ENCRYPT;
   logic [63:0]      req_block_in     = '0;
   logic             rsp_ready        = 1'b0;
   logic             csr_write_enable = 1'b0;
   logic [KEY_W-1:0] csr_write_data   = '0;
   wire              req_ready;
   wire              rsp_valid;
   wire  [63:0]      rsp_block_out;
   int unsigned      fail_count;
   int unsigned      pending_count;
   logic             no_idle = 1'b0;
   int unsigned      rsp_stall;

   feal4_block_cipher_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_block_in     (req_block_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_out    (rsp_block_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   feal4_block_cipher_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_block_in     (req_block_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_out    (rsp_block_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: after each word taken, hold ready low for a random stall, none while no_idle is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            rsp_stall = no_idle ? 0 : $urandom_range(0, 4);
         else if (rsp_stall > 0)
            rsp_stall--;
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // valid stays high across back-to-back words; it drops only for a gap or in drain
   task automatic send_block(input logic cmd, input logic [63:0] blk);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_block_in <= blk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_key(input logic [KEY_W-1:0] key);
      csr_write_enable <= 1'b1;
      csr_write_data   <= key;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [63:0]      corner[8];
      logic [KEY_W-1:0] key_plan[6];
      logic [63:0]      blk;
      int               phase, n, b;
      corner[0]   = 64'h0000000000000000;
      corner[1]   = 64'hFFFFFFFFFFFFFFFF;
      corner[2]   = 64'h00000000FFFFFFFF;
      corner[3]   = 64'hFFFFFFFF00000000;
      corner[4]   = 64'hAAAAAAAA55555555;
      corner[5]   = 64'h0123456789ABCDEF;
      corner[6]   = 64'h8080808080808080;
      corner[7]   = 64'h7F7F7F7F7F7F7F7F;
      key_plan[0] = '1;
      key_plan[1] = {$urandom, $urandom};
      key_plan[2] = 64'h5555AAAA5555AAAA;
      key_plan[3] = {$urandom, $urandom};
      key_plan[4] = '0;
      key_plan[5] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset key, both directions
      for (n = 0; n < 8; n++) begin
         send_block(CMD_ENCRYPT, corner[n]);
         send_block(CMD_DECRYPT, corner[n]);
      end

      for (phase = 0; phase < 6; phase++) begin
         drain();
         load_key(key_plan[phase]);
         for (n = 0; n < 340; n++) begin
            if (n % 40 == 0)
               no_idle <= ($urandom_range(0, 3) == 0);
            blk = {$urandom, $urandom};
            // some words get saturated bytes to push carries through the byte adds
            if ($urandom_range(0, 3) == 0) begin
               for (b = 0; b < 8; b++) begin
                  case ($urandom_range(0, 7))
                     0: blk[8*b +: 8] = 8'h00;
                     1: blk[8*b +: 8] = 8'hFF;
                     2: blk[8*b +: 8] = 8'h80;
                     3: blk[8*b +: 8] = 8'h7F;
                     default: ;
                  endcase
               end
            end
            send_block(($urandom_range(0, 1) == 1) ? CMD_DECRYPT : CMD_ENCRYPT, blk);
         end
      end

      drain();
      if (fail_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
